[src/gcdlcm_pkg.sv]
// ----------------------------------------------------------------------------
// gcdlcm_pkg: shared types and constants for the GCD / LCM unit
// Field widths and the command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gcdlcm_pkg;

  localparam int unsigned DATA_WIDTH = 32;  // operand and gcd field width
  localparam int unsigned LCM_WIDTH  = 64;  // lcm field width

  // Controller -> datapath
  typedef struct packed {
    logic load;      // capture operands, start GCD
    logic gcd_step;  // one binary GCD step
    logic div_step;  // one restoring divide step (a / g)
    logic mul;       // quotient times b
    logic publish;   // load output word
  } gcdlcm_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic zero;      // an operand was zero after masking
    logic gcd_done;  // u == v, gcd known
    logic div_last;  // final divide step
  } gcdlcm_sts_t;

endpackage

[src/gcdlcm_in_if.sv]
// ----------------------------------------------------------------------------
// gcdlcm_in_if: operand channel
// Valid/ready channel carrying one operand pair per word.
// ----------------------------------------------------------------------------
interface gcdlcm_in_if import gcdlcm_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] operand_a;
  logic [DATA_WIDTH-1:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

[src/gcdlcm_out_if.sv]
// ----------------------------------------------------------------------------
// gcdlcm_out_if: result channel
// Valid/ready channel carrying gcd, lcm and the zero operand flag per word.
// ----------------------------------------------------------------------------
interface gcdlcm_out_if import gcdlcm_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] gcd_value;
  logic [LCM_WIDTH-1:0]  lcm_value;
  logic                  zero_operand_error;

  modport source (output valid, output gcd_value, output lcm_value,
                  output zero_operand_error, input ready);
  modport sink   (input valid, input gcd_value, input lcm_value,
                  input zero_operand_error, output ready);
endinterface

[src/gcd_lcm_unit.sv]
// ----------------------------------------------------------------------------
// gcd_lcm_unit: greatest common divisor and least common multiple
// Controller plus datapath; one result word per operand word.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  (sink)  : operand_a, operand_b. Only the low OPERAND_WIDTH bits
//                    are used; upper bits are ignored.
//   out_ch (source): gcd_value, lcm_value (double width), zero_operand_error.
//   A word moves on a rising edge with valid and ready both high.
//
// Timing: one operand pair at a time. After accept the sequencer runs the
//   zero check, the binary GCD loop (data dependent length), the bit-serial
//   a/g divider, the multiply and the output load, in that order. While the
//   output is not stalled, the next pair can be taken in the same cycle as
//   the result shows. A zero operand skips the arithmetic: both values 0
//   and the error flag set.
//   in_ch.ready is high whenever the sequencer is idle, also while an
//   earlier result still sits in the output register.
//
// Stall: the result word holds in the output register until taken; a new
//   result waits in its final state until that register frees up.
// Reset (rst, synchronous): sequencer to idle, output valid cleared.
// ----------------------------------------------------------------------------
module gcd_lcm_unit import gcdlcm_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  gcdlcm_in_if.sink      in_ch,
  gcdlcm_out_if.source   out_ch
);

  // command / status bundle between sequencer and datapath
  gcdlcm_cmd_t cmd;
  gcdlcm_sts_t sts;

  // sequencer: handshakes and step order
  gcdlcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: masking, binary GCD, divide, multiply, output word
  gcdlcm_dpath #(
    .W (OPERAND_WIDTH)
  ) u_dpath (
    .clk                (clk),
    .rst                (rst),
    .operand_a          (in_ch.operand_a),
    .operand_b          (in_ch.operand_b),
    .cmd                (cmd),
    .sts                (sts),
    .gcd_value          (out_ch.gcd_value),
    .lcm_value          (out_ch.lcm_value),
    .zero_operand_error (out_ch.zero_operand_error)
  );

endmodule

[src/gcdlcm_dpath.sv]
// ----------------------------------------------------------------------------
// gcdlcm_dpath: GCD / LCM datapath
// Binary GCD step unit, restoring divider for a / g, one multiply, output regs.
// ----------------------------------------------------------------------------
module gcdlcm_dpath import gcdlcm_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [DATA_WIDTH-1:0] operand_a,
  input  logic [DATA_WIDTH-1:0] operand_b,
  input  gcdlcm_cmd_t           cmd,
  output gcdlcm_sts_t           sts,
  output logic [DATA_WIDTH-1:0] gcd_value,
  output logic [LCM_WIDTH-1:0]  lcm_value,
  output logic                  zero_operand_error
);

  localparam int unsigned KW = $clog2(W);

  logic [W-1:0]   a_reg, b_reg;
  logic [W-1:0]   u, v;
  logic [KW-1:0]  k;          // common power of two
  logic [W-1:0]   g_reg;
  logic [W-1:0]   quo, rem;
  logic [KW-1:0]  cnt;
  logic [2*W-1:0] prod;
  logic           zero_reg;

  logic [W-1:0]   a_in, b_in;
  logic [W-1:0]   diff_uv, diff_vu;
  logic [W:0]     trial, trial_sub;
  logic           fits;
  logic [2*W-1:0] mul_res;

  assign a_in = operand_a[W-1:0];
  assign b_in = operand_b[W-1:0];

  assign diff_uv = u - v;
  assign diff_vu = v - u;

  // restoring divide: shift in next dividend bit, try subtracting g
  assign trial     = {rem, quo[W-1]};
  assign trial_sub = trial - {1'b0, g_reg};
  assign fits      = ~trial_sub[W];

  assign mul_res = quo * b_reg;

  assign sts.zero     = zero_reg;
  assign sts.gcd_done = (u == v);
  assign sts.div_last = (cnt == KW'(W - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_reg    <= a_in;
      b_reg    <= b_in;
      u        <= a_in;
      v        <= b_in;
      k        <= '0;
      zero_reg <= (a_in == '0) || (b_in == '0);
    end

    if (cmd.gcd_step) begin
      priority if (u == v) begin
        g_reg <= u << k;
        quo   <= a_reg;
        rem   <= '0;
        cnt   <= '0;
      end else if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + 1'b1;
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u > v) begin
        u <= diff_uv >> 1;
      end else begin
        v <= diff_vu >> 1;
      end
    end

    if (cmd.div_step) begin
      quo <= {quo[W-2:0], fits};
      rem <= fits ? trial_sub[W-1:0] : trial[W-1:0];
      cnt <= cnt + 1'b1;
    end

    if (cmd.mul) begin
      prod <= mul_res;
    end

    if (cmd.publish) begin
      gcd_value          <= zero_reg ? '0 : DATA_WIDTH'(g_reg);
      lcm_value          <= zero_reg ? '0 : LCM_WIDTH'(prod);
      zero_operand_error <= zero_reg;
    end
  end

  // GCD loop only ever runs on nonzero values
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.gcd_step |-> (u != '0) && (v != '0))
    else $error("gcd step on zero value");

endmodule

[src/gcdlcm_ctrl.sv]
// ----------------------------------------------------------------------------
// gcdlcm_ctrl: GCD / LCM sequencer
// Walks load, zero check, GCD loop, divide, multiply and output handoff.
// ----------------------------------------------------------------------------
module gcdlcm_ctrl import gcdlcm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output gcdlcm_cmd_t cmd,
  input  gcdlcm_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_GCD,
    S_DIV,
    S_MUL,
    S_FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.gcd_step = (state == S_GCD);
    cmd.div_step = (state == S_DIV);
    cmd.mul      = (state == S_MUL);
    cmd.publish  = (state == S_FINISH) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE:   if (in_valid) state <= S_CHECK;
        S_CHECK:  state <= sts.zero ? S_FINISH : S_GCD;
        S_GCD:    if (sts.gcd_done) state <= S_DIV;
        S_DIV:    if (sts.div_last) state <= S_MUL;
        S_MUL:    state <= S_FINISH;
        S_FINISH: if (!out_valid || out_ready) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase

      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_load_to_check: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_CHECK)
    else $error("load not followed by zero check");

  a_zero_skips: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) && sts.zero |=> state == S_FINISH)
    else $error("zero operand did not skip arithmetic");

  a_div_to_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && sts.div_last |=> state == S_MUL)
    else $error("divide did not end in multiply");

  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> out_valid)
    else $error("published word not marked valid");

endmodule
